/* rtl/mma_pkg.sv */
// Shared constants and link types for the matrix multiply-accumulate block.
// No dependencies; imported by the cell, the top level and the checker.
`default_nettype none

package mma_pkg;

    localparam int MMA_DIM     = 4;
    localparam int MMA_DIM_MAX = 16;
    localparam int MMA_IDX_W   = $clog2(MMA_DIM_MAX);
    localparam int MMA_DATA_W  = 32;
    localparam int MMA_FRAC_W  = 16;

    localparam logic [MMA_DATA_W-1:0] MMA_SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [MMA_DATA_W-1:0] MMA_SAT_MIN = 32'h8000_0000;

    // one step of a row of A travelling down the chain
    typedef struct packed {
        logic                         valid;
        logic                         first;
        logic                         lastk;
        logic [MMA_IDX_W-1:0]         row;
        logic [MMA_IDX_W-1:0]         k;
        logic signed [MMA_DATA_W-1:0] a;
    } mma_link_t;

    // load beat steered to the cell that owns the column
    typedef struct packed {
        logic                  en;
        logic [MMA_IDX_W-1:0]  row;
        logic [MMA_IDX_W-1:0]  col;
        logic [MMA_DATA_W-1:0] b;
        logic [MMA_DATA_W-1:0] c;
    } mma_wr_t;

    // read-out control for the C column stores
    typedef struct packed {
        logic                 out_mode;
        logic [MMA_IDX_W-1:0] row;
    } mma_rd_t;

endpackage

`default_nettype wire

/* rtl/mma_cell.sv */
// One column cell: holds a column of B and of C, multiplies and accumulates.
// Depends on mma_pkg.
`default_nettype none

module mma_cell
    import mma_pkg::*;
#(
    parameter int DIM = MMA_DIM,
    parameter int COL = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mma_link_t             link_i,
    output mma_link_t             link_o,
    input  mma_wr_t               wr_i,
    input  mma_rd_t               rd_i,
    output logic [MMA_DATA_W-1:0] c_rd_o,
    output logic                  busy_o
);

    localparam int IDX_W = $clog2(DIM);
    localparam int ACC_W = 2 * MMA_DATA_W + $clog2(DIM + 1);
    localparam int Q_W   = ACC_W - MMA_FRAC_W;

    logic [MMA_DATA_W-1:0] b_mem [DIM];
    logic [MMA_DATA_W-1:0] c_mem [DIM];

    mma_link_t                    link_reg;
    logic signed [MMA_DATA_W-1:0] b_reg;
    logic [MMA_DATA_W-1:0]        c_rd_reg;

    logic                           p_vld_reg;
    logic                           p_first_reg;
    logic                           p_last_reg;
    logic [IDX_W-1:0]               p_row_reg;
    logic signed [2*MMA_DATA_W-1:0] prod_reg;
    logic signed [MMA_DATA_W-1:0]   c2_reg;

    logic              acc_vld_reg;
    logic              acc_last_reg;
    logic [IDX_W-1:0]  acc_row_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    logic signed [Q_W-1:0]  q;
    logic [MMA_DATA_W-1:0]  sat_val;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_hit;

    assign rd_addr = rd_i.out_mode ? rd_i.row[IDX_W-1:0] : link_i.row[IDX_W-1:0];
    assign wr_hit  = wr_i.en && (wr_i.col == MMA_IDX_W'(COL));

    always_comb begin
        acc_next = (p_first_reg ? (ACC_W'(c2_reg) <<< MMA_FRAC_W) : acc_reg)
                 + ACC_W'(prod_reg);
    end

    // truncate toward zero, then clamp to 32 bits
    always_comb begin
        q = Q_W'(acc_reg >>> MMA_FRAC_W)
          + Q_W'(acc_reg[ACC_W-1] && (|acc_reg[MMA_FRAC_W-1:0]));
        if ((&q[Q_W-1:MMA_DATA_W-1]) || !(|q[Q_W-1:MMA_DATA_W-1])) begin
            sat_val = q[MMA_DATA_W-1:0];
        end else if (q[Q_W-1]) begin
            sat_val = MMA_SAT_MIN;
        end else begin
            sat_val = MMA_SAT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_hit) begin
            b_mem[wr_i.row[IDX_W-1:0]] <= wr_i.b;
            c_mem[wr_i.row[IDX_W-1:0]] <= wr_i.c;
        end
        if (acc_vld_reg && acc_last_reg) begin
            c_mem[acc_row_reg] <= sat_val;
        end
        b_reg    <= b_mem[link_i.k[IDX_W-1:0]];
        c_rd_reg <= c_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        p_first_reg  <= link_reg.first;
        p_last_reg   <= link_reg.lastk;
        p_row_reg    <= link_reg.row[IDX_W-1:0];
        prod_reg     <= link_reg.a * b_reg;
        c2_reg       <= c_rd_reg;
        acc_last_reg <= p_last_reg;
        acc_row_reg  <= p_row_reg;
        if (p_vld_reg) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg    <= '0;
            p_vld_reg   <= 1'b0;
            acc_vld_reg <= 1'b0;
        end else begin
            link_reg    <= link_i;
            p_vld_reg   <= link_reg.valid;
            acc_vld_reg <= p_vld_reg;
        end
    end

    assign link_o = link_reg;
    assign c_rd_o = c_rd_reg;
    assign busy_o = p_vld_reg || acc_vld_reg;

endmodule

`default_nettype wire

/* rtl/matrix_multiply_accumulate.sv */
// Top level: load sequencer, A store, chain of column cells and result stream.
// Depends on mma_pkg and mma_cell.
//
//   channel | dir | tdata (low bit up)                  | tlast
//   s_      | in  | a_element, b_element, c_element     | last_element
//   m_      | out | result_element                      | last_result
//
// A load beat is accepted only in the load state. The beat with tlast starts the
// compute: A elements enter the chain at one per cycle, one MAC per cell per
// cycle; once the chain drains, each result passes through ISSUE and then CAP.
// Reset is synchronous and clears all control; the stores hold their contents.
// A stalled result holds in the output register; loading resumes while the
// final result of a matrix still waits.
`default_nettype none

module matrix_multiply_accumulate
    import mma_pkg::*;
#(
    parameter int DIM = MMA_DIM
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [3*MMA_DATA_W-1:0] s_tdata,   // a_element, b_element, c_element
    input  logic                    s_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [MMA_DATA_W-1:0]   m_tdata,   // result_element
    output logic                    m_tlast
);

    localparam int IDX_W  = $clog2(DIM);
    localparam int ROW_W  = $clog2(DIM + 1);
    localparam int ELEMS  = DIM * DIM;
    localparam int ADDR_W = $clog2(ELEMS);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_COMP,
        ST_ISSUE,
        ST_CAP
    } state_t;

    state_t state_reg;

    logic [MMA_DATA_W-1:0] a_mem [ELEMS];

    logic [ROW_W-1:0]  ld_row_reg;
    logic [IDX_W-1:0]  ld_col_reg;
    logic [ADDR_W-1:0] ld_addr_reg;

    logic              cp_act_reg;
    logic [IDX_W-1:0]  cp_row_reg;
    logic [IDX_W-1:0]  cp_k_reg;
    logic [ADDR_W-1:0] cp_addr_reg;

    logic                         head_vld_reg;
    logic                         head_first_reg;
    logic                         head_last_reg;
    logic [IDX_W-1:0]             head_row_reg;
    logic [IDX_W-1:0]             head_k_reg;
    logic signed [MMA_DATA_W-1:0] head_a_reg;

    logic [IDX_W-1:0]      out_row_reg;
    logic [IDX_W-1:0]      out_col_reg;
    logic                  m_tvalid_reg;
    logic [MMA_DATA_W-1:0] m_tdata_reg;
    logic                  m_tlast_reg;

    logic                  s_accept;
    logic                  ld_full;
    logic                  ld_wr;
    logic                  chain_busy;
    mma_link_t             head_link;
    mma_wr_t               wr;
    mma_rd_t               rd;
    mma_link_t             link_in  [DIM];
    mma_link_t             link_out [DIM];
    logic [MMA_DATA_W-1:0] cell_rd  [DIM];
    logic [DIM-1:0]        cell_busy;
    logic [DIM-1:0]        link_vld;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign ld_full  = (ld_row_reg == ROW_W'(DIM));
    assign ld_wr    = s_accept && !ld_full;

    assign chain_busy = head_vld_reg || (|cell_busy) || (|link_vld);

    always_comb begin
        head_link.valid = head_vld_reg;
        head_link.first = head_first_reg;
        head_link.lastk = head_last_reg;
        head_link.row   = MMA_IDX_W'(head_row_reg);
        head_link.k     = MMA_IDX_W'(head_k_reg);
        head_link.a     = head_a_reg;

        wr.en  = ld_wr;
        wr.row = MMA_IDX_W'(ld_row_reg[IDX_W-1:0]);
        wr.col = MMA_IDX_W'(ld_col_reg);
        wr.b   = s_tdata[2*MMA_DATA_W-1:MMA_DATA_W];
        wr.c   = s_tdata[3*MMA_DATA_W-1:2*MMA_DATA_W];

        rd.out_mode = (state_reg == ST_ISSUE) || (state_reg == ST_CAP);
        rd.row      = MMA_IDX_W'(out_row_reg);
    end

    always_ff @(posedge aclk) begin
        if (ld_wr) begin
            a_mem[ld_addr_reg] <= s_tdata[MMA_DATA_W-1:0];
        end
        head_a_reg <= a_mem[cp_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            ld_row_reg   <= '0;
            ld_col_reg   <= '0;
            ld_addr_reg  <= '0;
            cp_act_reg   <= 1'b0;
            cp_row_reg   <= '0;
            cp_k_reg     <= '0;
            cp_addr_reg  <= '0;
            head_vld_reg <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            head_vld_reg   <= cp_act_reg;
            head_first_reg <= (cp_k_reg == '0);
            head_last_reg  <= (cp_k_reg == IDX_W'(DIM - 1));
            head_row_reg   <= cp_row_reg;
            head_k_reg     <= cp_k_reg;

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_LOAD: begin
                    if (s_accept) begin
                        if (!ld_full) begin
                            ld_addr_reg <= ld_addr_reg + ADDR_W'(1);
                            if (ld_col_reg == IDX_W'(DIM - 1)) begin
                                ld_col_reg <= '0;
                                ld_row_reg <= ld_row_reg + ROW_W'(1);
                            end else begin
                                ld_col_reg <= ld_col_reg + IDX_W'(1);
                            end
                        end
                        if (s_tlast) begin
                            ld_row_reg  <= '0;
                            ld_col_reg  <= '0;
                            ld_addr_reg <= '0;
                            cp_act_reg  <= 1'b1;
                            cp_row_reg  <= '0;
                            cp_k_reg    <= '0;
                            cp_addr_reg <= '0;
                            state_reg   <= ST_COMP;
                        end
                    end
                end
                ST_COMP: begin
                    if (cp_act_reg) begin
                        cp_addr_reg <= cp_addr_reg + ADDR_W'(1);
                        if (cp_k_reg == IDX_W'(DIM - 1)) begin
                            cp_k_reg <= '0;
                            if (cp_row_reg == IDX_W'(DIM - 1)) begin
                                cp_act_reg <= 1'b0;
                            end else begin
                                cp_row_reg <= cp_row_reg + IDX_W'(1);
                            end
                        end else begin
                            cp_k_reg <= cp_k_reg + IDX_W'(1);
                        end
                    end else if (!chain_busy) begin
                        out_row_reg <= '0;
                        out_col_reg <= '0;
                        state_reg   <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= ST_CAP;
                    end
                end
                ST_CAP: begin
                    m_tvalid_reg <= 1'b1;
                    m_tdata_reg  <= cell_rd[out_col_reg];
                    m_tlast_reg  <= (out_row_reg == IDX_W'(DIM - 1))
                                 && (out_col_reg == IDX_W'(DIM - 1));
                    state_reg    <= ST_ISSUE;
                    if (out_col_reg == IDX_W'(DIM - 1)) begin
                        out_col_reg <= '0;
                        if (out_row_reg == IDX_W'(DIM - 1)) begin
                            state_reg <= ST_LOAD;
                        end else begin
                            out_row_reg <= out_row_reg + IDX_W'(1);
                        end
                    end else begin
                        out_col_reg <= out_col_reg + IDX_W'(1);
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    for (genvar j = 0; j < DIM; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign link_in[j] = head_link;
        end else begin : g_link
            assign link_in[j] = link_out[j-1];
        end

        mma_cell #(
            .DIM (DIM),
            .COL (j)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .link_i  (link_in[j]),
            .link_o  (link_out[j]),
            .wr_i    (wr),
            .rd_i    (rd),
            .c_rd_o  (cell_rd[j]),
            .busy_o  (cell_busy[j])
        );

        assign link_vld[j] = link_out[j].valid;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

/* rtl/mma_checker.sv */
// Port-level checks on the matrix multiply-accumulate block, bound to the top.
// Depends on mma_pkg and matrix_multiply_accumulate.
`default_nettype none

module mma_checker
    import mma_pkg::*;
#(
    parameter int DIM = MMA_DIM
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [MMA_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    localparam int ELEMS = DIM * DIM;
    localparam int CNT_W = $clog2(ELEMS);

    logic [CNT_W-1:0] beat_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_cnt_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            if (m_tlast) begin
                beat_cnt_reg <= '0;
            end else begin
                beat_cnt_reg <= beat_cnt_reg + CNT_W'(1);
            end
        end
    end

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_m_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |-> (m_tlast == (beat_cnt_reg == CNT_W'(ELEMS - 1))))
        else $error("tlast not on the final result of a matrix");

    a_s_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("load taken after the final load beat");

    a_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && s_tready |-> m_tlast)
        else $error("loading while results other than the final one wait");

endmodule

bind matrix_multiply_accumulate mma_checker #(
    .DIM (DIM)
) u_mma_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/testbench.sv */
// Self-checking bench for matrix_multiply_accumulate: drives matrix loads on the
// slave stream, predicts C + A*B in Q16.16 and checks every result beat in order.
// Depends on mma_pkg and the block's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mma_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int ELEMS        = MMA_DIM * MMA_DIM;
    localparam int N_ITEMS      = 370;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_LOGGED   = 40;

    typedef struct packed {
        logic [MMA_DATA_W-1:0] a;
        logic [MMA_DATA_W-1:0] b;
        logic [MMA_DATA_W-1:0] c;
        logic                  last;
    } load_beat_t;

    typedef struct packed {
        logic [MMA_DATA_W-1:0] value;
        logic                  tail;
    } mac_result_t;

    class mac_scoreboard;
        logic [MMA_DATA_W-1:0] a_mat[ELEMS];
        logic [MMA_DATA_W-1:0] b_mat[ELEMS];
        logic [MMA_DATA_W-1:0] c_mat[ELEMS];
        int unsigned           fill;
        mac_result_t           due_results[$];
        int unsigned           fail_count;
        int unsigned           beats_seen;

        function new();
            foreach (a_mat[i]) begin
                a_mat[i] = '0;
                b_mat[i] = '0;
                c_mat[i] = '0;
            end
            fill       = 0;
            fail_count = 0;
            beats_seen = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function logic [MMA_DATA_W-1:0] round_saturate(logic signed [79:0] acc);
            logic signed [79:0] q;
            q = acc / (80'sd1 <<< MMA_FRAC_W);
            if (q > 80'sd2147483647)
                return MMA_SAT_MAX;
            if (q < -80'sd2147483648)
                return MMA_SAT_MIN;
            return q[MMA_DATA_W-1:0];
        endfunction

        function void compute_mac_results();
            logic [MMA_DATA_W-1:0] r[ELEMS];
            logic signed [79:0]    acc;
            logic signed [79:0]    x;
            logic signed [79:0]    y;
            mac_result_t           res;
            for (int i = 0; i < MMA_DIM; i++) begin
                for (int j = 0; j < MMA_DIM; j++) begin
                    x   = $signed(c_mat[i*MMA_DIM+j]);
                    acc = x <<< MMA_FRAC_W;
                    for (int k = 0; k < MMA_DIM; k++) begin
                        x   = $signed(a_mat[i*MMA_DIM+k]);
                        y   = $signed(b_mat[k*MMA_DIM+j]);
                        acc = acc + x * y;
                    end
                    r[i*MMA_DIM+j] = round_saturate(acc);
                end
            end
            for (int n = 0; n < ELEMS; n++) begin
                c_mat[n]  = r[n];
                res.value = r[n];
                res.tail  = (n == ELEMS - 1);
                due_results.push_back(res);
            end
        endfunction

        function void note_load(load_beat_t bt);
            if (fill < ELEMS) begin
                a_mat[fill] = bt.a;
                b_mat[fill] = bt.b;
                c_mat[fill] = bt.c;
                fill++;
            end
            if (bt.last) begin
                compute_mac_results();
                fill = 0;
            end
        endfunction

        task report_mismatch(string msg);
            // keep the log short
            if (fail_count < MAX_LOGGED)
                $display("[%0t] mismatch: %s", $time, msg);
            fail_count++;
        endtask

        task check_result(logic [MMA_DATA_W-1:0] value, logic tail);
            mac_result_t exp_res;
            beats_seen++;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result beat %0d (%h) with none pending",
                                          beats_seen, value));
                return;
            end
            exp_res = due_results.pop_front();
            if (value !== exp_res.value)
                report_mismatch($sformatf("result beat %0d: element %h, predicted %h",
                                          beats_seen, value, exp_res.value));
            if (tail !== exp_res.tail)
                report_mismatch($sformatf("result beat %0d: tlast %b, predicted %b",
                                          beats_seen, tail, exp_res.tail));
        endtask

        task close_out();
            if (due_results.size() != 0)
                report_mismatch($sformatf("%0d result beats never arrived",
                                          due_results.size()));
        endtask
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [3*MMA_DATA_W-1:0] s_tdata;   // a_element, b_element, c_element
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [MMA_DATA_W-1:0]   m_tdata;   // result_element
    logic                    m_tlast;

    mac_scoreboard sb;
    bit            steady = 1'b0;
    int            counted = 0;

    matrix_multiply_accumulate dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [MMA_DATA_W-1:0] pick_value();
        logic [MMA_DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
            4, 5:       v = $urandom;
            6: begin
                case ($urandom_range(0, 3))
                    0:       v = MMA_SAT_MAX;
                    1:       v = MMA_SAT_MIN;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default:    v = $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
        endcase
        return v;
    endfunction

    function automatic load_beat_t make_beat(logic last);
        load_beat_t bt;
        bt.a    = pick_value();
        bt.b    = pick_value();
        bt.c    = pick_value();
        bt.last = last;
        return bt;
    endfunction

    task automatic send_beat(input load_beat_t bt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bt.c, bt.b, bt.a};
        s_tlast  <= bt.last;
        do @(posedge aclk); while (!s_tready);
        if (sb.fill < ELEMS || bt.last)
            counted++;
        sb.note_load(bt);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_frame(input int len);
        for (int n = 0; n < len; n++)
            send_beat(make_beat(n == len - 1));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    initial begin
        int hold;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    initial begin
        #15ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        load_beat_t bt;
        int         frame_no;
        int         len;
        int         w;
        sb       = new();
        frame_no = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full load of small values, negative fractions truncate toward zero
        for (int i = 0; i < ELEMS; i++) begin
            bt.a    = (i % 2) ? 32'h0000_8000 : 32'hFFFF_4000;
            bt.b    = (i % 3 == 0) ? 32'h0001_8000 : 32'hFFFE_C001;
            bt.c    = (i % 4 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            bt.last = (i == ELEMS - 1);
            send_beat(bt);
        end
        drain_results();

        // short load of row 0 with extremes: saturate both ways, keep the rest
        for (int i = 0; i < MMA_DIM; i++) begin
            bt.a    = (i % 2) ? MMA_SAT_MIN : MMA_SAT_MAX;
            bt.b    = (i < 2) ? MMA_SAT_MAX : MMA_SAT_MIN;
            bt.c    = (i == 0) ? MMA_SAT_MAX : (i == 1) ? MMA_SAT_MIN : 32'(i - 2);
            bt.last = (i == MMA_DIM - 1);
            send_beat(bt);
        end

        // single beat with tlast: C element 0 reloaded as zero, the rest accumulate onto the previous result
        bt.a    = 32'h0000_0001;
        bt.b    = 32'hFFFF_FFFF;
        bt.c    = 32'h0000_0000;
        bt.last = 1'b1;
        send_beat(bt);

        while (counted < N_ITEMS) begin
            frame_no++;
            steady = ($urandom_range(0, 5) == 0);
            if (frame_no % 8 == 0)
                drain_results();
            case ((frame_no == 1) ? 9 : $urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: len = ELEMS;
                7, 8:                len = $urandom_range(1, ELEMS - 1);
                default:             len = ELEMS + 1 + $urandom_range(0, 3);
            endcase
            send_frame(len);
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        for (w = 0; w < 50000 && sb.pending() != 0; w++) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.close_out();
        if (sb.fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
